// File: rtl/core/sco_pkg.sv
// Package for the segment corner offset core: widths, beat types and the
// state records that travel along the square-root and divider cell chains.
// No dependencies.
package sco_pkg;

  localparam int COORD_BITS = 24;
  localparam int LW_BITS    = 16;
  localparam int LC_BITS    = 4;
  localparam int D_BITS     = LW_BITS + LC_BITS;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int LEN_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * LEN_BITS;
  localparam int ROOTREM_BITS = LEN_BITS + 2;
  localparam int PROD_BITS  = D_BITS + MAG_BITS;
  localparam int NUM_BITS   = D_BITS + COORD_BITS + 3;
  localparam int Q_BITS     = D_BITS;
  localparam int DVS_BITS   = LEN_BITS + 1;
  localparam int REM_BITS   = NUM_BITS - Q_BITS;
  localparam int SUM_BITS   = ((COORD_BITS > Q_BITS + 1) ? COORD_BITS : Q_BITS + 1) + 1;
  localparam int PADDR_BITS = 3;

  localparam logic [PADDR_BITS-1:0] ADDR_LANE_PITCH = 3'd0;
  localparam logic [LW_BITS-1:0]    LANE_PITCH_RESET = 16'd768;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [LC_BITS-1:0]    lane_count;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_start_x;
    logic signed [COORD_BITS-1:0] left_start_y;
    logic signed [COORD_BITS-1:0] right_start_x;
    logic signed [COORD_BITS-1:0] right_start_y;
    logic signed [COORD_BITS-1:0] left_end_x;
    logic signed [COORD_BITS-1:0] left_end_y;
    logic signed [COORD_BITS-1:0] right_end_x;
    logic signed [COORD_BITS-1:0] right_end_y;
    logic        [LEN_BITS-1:0]   segment_length;
    logic                         degenerate;
    logic                         clipped;
  } seg_out_t;

  // Endpoints and sign flags that ride along with every item.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         dx_neg;
    logic                         dy_pos;
    logic                         degen;
  } geo_t;

  typedef struct packed {
    geo_t                    geo;
    logic [NUM_BITS-1:0]     num_x;
    logic [NUM_BITS-1:0]     num_y;
    logic [SQ_BITS-1:0]      s;
    logic [LEN_BITS-1:0]     root;
    logic [ROOTREM_BITS-1:0] rem;
  } sq_state_t;

  typedef struct packed {
    geo_t                geo;
    logic [LEN_BITS-1:0] len;
    logic [DVS_BITS-1:0] dvs;
    logic [REM_BITS-1:0] rem_x;
    logic [REM_BITS-1:0] rem_y;
    logic [Q_BITS-1:0]   nlo_x;
    logic [Q_BITS-1:0]   nlo_y;
    logic [Q_BITS-1:0]   q_x;
    logic [Q_BITS-1:0]   q_y;
  } div_state_t;

endpackage

// File: rtl/core/segment_corner_offset_core.sv
// Top level of the segment corner offset core: configuration port, the
// square-root and divider cell chains and the output stage.
// Depends on sco_pkg, sco_prep, sco_sqrt_cell, sco_div_cell and sco_post.

// The core takes one segment beat in every clock cycle and never raises
// busy, so start may be held high continuously. Each beat produces exactly
// one result beat, marked by done for a single cycle, after it passes through
// four front stages (differences, squares and numerators), one cell per bit
// of the 25-bit length in the square-root chain, one rounding stage, one
// cell per bit of the 20-bit offset magnitude in the divider chain, and one
// output register. The receiver cannot stall results, so it must take every
// done beat as it appears. The lane width register sits at byte address 0
// and should only be written while no beat is in flight.
module segment_corner_offset_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  sco_pkg::seg_in_t                item,
  output logic                            done,
  output sco_pkg::seg_out_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sco_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sco_pkg::*;

  logic [LW_BITS-1:0] lane_pitch;
  logic               accept;

  logic       sq_valid [LEN_BITS+1];
  sq_state_t  sq_state [LEN_BITS+1];
  logic       dv_valid [Q_BITS+1];
  div_state_t dv_state [Q_BITS+1];

  logic [LEN_BITS-1:0] len_rnd;
  logic [NUM_BITS-1:0] nx, ny;

  // The pipeline never backs up, so an item is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_pitch <= LANE_PITCH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_LANE_PITCH)) begin
      lane_pitch <= pwdata[LW_BITS-1:0];
    end
  end

  assign prdata = (paddr == ADDR_LANE_PITCH) ? 32'(lane_pitch) : 32'd0;

  sco_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_beat   (item),
    .lane_pitch(lane_pitch),
    .out_valid (sq_valid[0]),
    .out_state (sq_state[0])
  );

  // Square-root chain: each cell decides one bit of floor(sqrt(S)) and
  // keeps the running remainder S - root^2.
  for (genvar i = 0; i < LEN_BITS; i++) begin : g_sqrt
    sco_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_valid[i]),
      .in_state (sq_state[i]),
      .out_valid(sq_valid[i+1]),
      .out_state(sq_state[i+1])
    );
  end

  // Round to nearest: bump the root when the remainder exceeds it, which
  // is the same as S >= root^2 + root + 1. The divisor is twice the length
  // and the numerators gain the length as the rounding half.
  always_comb begin
    len_rnd = sq_state[LEN_BITS].root +
              LEN_BITS'(sq_state[LEN_BITS].rem > ROOTREM_BITS'(sq_state[LEN_BITS].root));
    nx = sq_state[LEN_BITS].num_x + NUM_BITS'(len_rnd);
    ny = sq_state[LEN_BITS].num_y + NUM_BITS'(len_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[LEN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    dv_state[0].geo   <= sq_state[LEN_BITS].geo;
    dv_state[0].len   <= len_rnd;
    dv_state[0].dvs   <= {len_rnd, 1'b0};
    dv_state[0].rem_x <= nx[NUM_BITS-1:Q_BITS];
    dv_state[0].rem_y <= ny[NUM_BITS-1:Q_BITS];
    dv_state[0].nlo_x <= nx[Q_BITS-1:0];
    dv_state[0].nlo_y <= ny[Q_BITS-1:0];
    dv_state[0].q_x   <= '0;
    dv_state[0].q_y   <= '0;
  end

  // Divider chain: the offset magnitude never exceeds the lane offset d,
  // so one cell per bit of d covers the whole quotient.
  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    sco_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_valid[j]),
      .in_state (dv_state[j]),
      .out_valid(dv_valid[j+1]),
      .out_state(dv_state[j+1])
    );
  end

  sco_post u_post (
    .clk     (clk),
    .rst     (rst),
    .in_valid(dv_valid[Q_BITS]),
    .in_state(dv_state[Q_BITS]),
    .done    (done),
    .result  (result)
  );

endmodule

// File: rtl/core/sco_prep.sv
// Front stages of the segment corner offset core: differences, magnitudes,
// squares and offset numerators. Depends on sco_pkg.
module sco_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  sco_pkg::seg_in_t              in_beat,
  input  logic [sco_pkg::LW_BITS-1:0]   lane_pitch,
  output logic                          out_valid,
  output sco_pkg::sq_state_t            out_state
);
  import sco_pkg::*;

  logic                 a_valid, b_valid, c_valid;
  seg_in_t              a_beat;
  logic [D_BITS-1:0]    a_d, b_d;
  geo_t                 b_geo, c_geo;
  logic [MAG_BITS-1:0]  b_ax, b_ay;
  logic [SQ_BITS-1:0]   c_sqx, c_sqy;
  logic [PROD_BITS-1:0] c_px, c_py;
  logic signed [COORD_BITS:0] dx, dy;
  logic [MAG_BITS-1:0]  ax, ay;

  always_comb begin
    dx = ({a_beat.end_x[COORD_BITS-1], a_beat.end_x}
         - {a_beat.start_x[COORD_BITS-1], a_beat.start_x});
    dy = ({a_beat.end_y[COORD_BITS-1], a_beat.end_y}
         - {a_beat.start_y[COORD_BITS-1], a_beat.start_y});
    ax = dx[COORD_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    ay = dy[COORD_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_beat <= in_beat;
    a_d    <= D_BITS'(lane_pitch) * D_BITS'(in_beat.lane_count);

    b_d          <= a_d;
    b_ax         <= ax;
    b_ay         <= ay;
    b_geo.sx     <= a_beat.start_x;
    b_geo.sy     <= a_beat.start_y;
    b_geo.ex     <= a_beat.end_x;
    b_geo.ey     <= a_beat.end_y;
    b_geo.dx_neg <= dx[COORD_BITS];
    b_geo.dy_pos <= !dy[COORD_BITS] && (dy != '0);
    b_geo.degen  <= (dx == '0) && (dy == '0);

    c_geo <= b_geo;
    c_sqx <= SQ_BITS'(b_ax) * SQ_BITS'(b_ax);
    c_sqy <= SQ_BITS'(b_ay) * SQ_BITS'(b_ay);
    c_px  <= PROD_BITS'(b_d) * PROD_BITS'(b_ax);
    c_py  <= PROD_BITS'(b_d) * PROD_BITS'(b_ay);

    out_state.geo   <= c_geo;
    out_state.s     <= c_sqx + c_sqy;
    out_state.num_x <= NUM_BITS'({c_px, 1'b0});
    out_state.num_y <= NUM_BITS'({c_py, 1'b0});
    out_state.root  <= '0;
    out_state.rem   <= '0;
  end

endmodule

// File: rtl/core/sco_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per item.
// Depends on sco_pkg.
module sco_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sco_pkg::sq_state_t in_state,
  output logic               out_valid,
  output sco_pkg::sq_state_t out_state
);
  import sco_pkg::*;

  logic [ROOTREM_BITS+1:0] rem_sh, trial;
  logic                    take;

  always_comb begin
    rem_sh = {in_state.rem, in_state.s[SQ_BITS-1 -: 2]};
    trial  = (ROOTREM_BITS+2)'({in_state.root, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state.geo   <= in_state.geo;
    out_state.num_x <= in_state.num_x;
    out_state.num_y <= in_state.num_y;
    out_state.s     <= {in_state.s[SQ_BITS-3:0], 2'b00};
    out_state.root  <= {in_state.root[LEN_BITS-2:0], take};
    out_state.rem   <= take ? ROOTREM_BITS'(rem_sh - trial) : ROOTREM_BITS'(rem_sh);
  end

endmodule

// File: rtl/core/sco_div_cell.sv
// One cell of the twin divider chain: settles one quotient bit of both
// offset magnitudes per item. Depends on sco_pkg.
module sco_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sco_pkg::div_state_t in_state,
  output logic                out_valid,
  output sco_pkg::div_state_t out_state
);
  import sco_pkg::*;

  logic [REM_BITS-1:0] rsh_x, rsh_y, dvs_ext;
  logic                take_x, take_y;

  always_comb begin
    dvs_ext = REM_BITS'(in_state.dvs);
    rsh_x   = {in_state.rem_x[REM_BITS-2:0], in_state.nlo_x[Q_BITS-1]};
    rsh_y   = {in_state.rem_y[REM_BITS-2:0], in_state.nlo_y[Q_BITS-1]};
    take_x  = (rsh_x >= dvs_ext);
    take_y  = (rsh_y >= dvs_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state.geo   <= in_state.geo;
    out_state.len   <= in_state.len;
    out_state.dvs   <= in_state.dvs;
    out_state.rem_x <= take_x ? (rsh_x - dvs_ext) : rsh_x;
    out_state.rem_y <= take_y ? (rsh_y - dvs_ext) : rsh_y;
    out_state.nlo_x <= {in_state.nlo_x[Q_BITS-2:0], 1'b0};
    out_state.nlo_y <= {in_state.nlo_y[Q_BITS-2:0], 1'b0};
    out_state.q_x   <= {in_state.q_x[Q_BITS-2:0], take_x};
    out_state.q_y   <= {in_state.q_y[Q_BITS-2:0], take_y};
  end

endmodule

// File: rtl/core/sco_post.sv
// Output stage: applies offset signs, forms the four corners, saturates
// them and registers the result beat. Depends on sco_pkg.
module sco_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sco_pkg::div_state_t in_state,
  output logic                done,
  output sco_pkg::seg_out_t   result
);
  import sco_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (COORD_BITS-1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

  logic signed [SUM_BITS-1:0] ox, oy, qx, qy;
  logic signed [SUM_BITS-1:0] sum [8];
  logic [COORD_BITS-1:0]      sat [8];
  logic [7:0]                 clip;

  always_comb begin
    // Magnitude from |dy| feeds the x offset, from |dx| the y offset.
    qy = in_state.geo.degen ? '0 : SUM_BITS'(in_state.q_y);
    qx = in_state.geo.degen ? '0 : SUM_BITS'(in_state.q_x);
    ox = in_state.geo.dy_pos ? -qy : qy;
    oy = in_state.geo.dx_neg ? -qx : qx;
    sum[0] = SUM_BITS'(in_state.geo.sx) + ox;
    sum[1] = SUM_BITS'(in_state.geo.sy) + oy;
    sum[2] = SUM_BITS'(in_state.geo.sx) - ox;
    sum[3] = SUM_BITS'(in_state.geo.sy) - oy;
    sum[4] = SUM_BITS'(in_state.geo.ex) + ox;
    sum[5] = SUM_BITS'(in_state.geo.ey) + oy;
    sum[6] = SUM_BITS'(in_state.geo.ex) - ox;
    sum[7] = SUM_BITS'(in_state.geo.ey) - oy;
    for (int i = 0; i < 8; i++) begin
      if (sum[i] > SAT_HI) begin
        sat[i]  = COORD_BITS'(SAT_HI);
        clip[i] = 1'b1;
      end else if (sum[i] < SAT_LO) begin
        sat[i]  = COORD_BITS'(SAT_LO);
        clip[i] = 1'b1;
      end else begin
        sat[i]  = COORD_BITS'(sum[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.left_start_x   <= sat[0];
    result.left_start_y   <= sat[1];
    result.right_start_x  <= sat[2];
    result.right_start_y  <= sat[3];
    result.left_end_x     <= sat[4];
    result.left_end_y     <= sat[5];
    result.right_end_x    <= sat[6];
    result.right_end_y    <= sat[7];
    result.segment_length <= in_state.len;
    result.degenerate     <= in_state.geo.degen;
    result.clipped        <= |clip;
  end

endmodule
